### hw/rtl/byte_stream_pixel_colorizer_core_macros.svh
// Assertion macros shared by the colorizer RTL.
// Depends on nothing; each use names its own clock and reset.
`ifndef BYTE_STREAM_PIXEL_COLORIZER_CORE_MACROS_SVH
`define BYTE_STREAM_PIXEL_COLORIZER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define BSPC_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define BSPC_NEVER(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define BSPC_ASSERT(lbl, ck, rn, prop, msg)
`define BSPC_NEVER(lbl, ck, rn, cond, msg)
`endif
`endif

### hw/rtl/bspc_pkg.sv
// Package for the byte stream pixel colorizer: payload types, codes and
// the palette function. Depends on nothing.
package bspc_pkg;

    localparam int MAX_ROW_WIDTH = 4096;
    localparam int MAX_ZOOM = 64;
    localparam int MAX_SKIP = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] MODE_GRAY = 4'd0;
    localparam logic [3:0] MODE_GRAY16_BIG = 4'd1;
    localparam logic [3:0] MODE_GRAY32_BIG = 4'd2;
    localparam logic [3:0] MODE_GRAY16_LITTLE = 4'd3;
    localparam logic [3:0] MODE_GRAY32_LITTLE = 4'd4;
    localparam logic [3:0] MODE_HUES = 4'd5;
    localparam logic [3:0] MODE_HUES6 = 4'd6;
    localparam logic [3:0] MODE_FHUES = 4'd7;
    localparam logic [3:0] MODE_COLOR = 4'd8;
    localparam logic [3:0] MODE_COLOR16 = 4'd9;
    localparam logic [3:0] MODE_COLOR32 = 4'd10;
    localparam logic [3:0] MODE_RGB = 4'd11;
    localparam logic [3:0] MODE_DVI = 4'd12;
    localparam logic [3:0] MODE_X86 = 4'd13;

    localparam logic [2:0] CFG_PALETTE_MODE = 3'd0;
    localparam logic [2:0] CFG_ROW_WIDTH = 3'd1;
    localparam logic [2:0] CFG_ROW_SKIP = 3'd2;
    localparam logic [2:0] CFG_PIXEL_ZOOM = 3'd3;
    localparam logic [2:0] CFG_MASK_LOW_BIT = 3'd4;

    localparam logic [7:0] MARK_HI = 8'hff;
    localparam logic [7:0] MARK_MID = 8'hcf;
    localparam logic [7:0] MARK_LO = 8'haf;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       filler;
        logic       final_res;
    } out_t;

    typedef struct packed {
        logic [3:0]  palette_mode;
        logic [12:0] row_width;
        logic [6:0]  row_skip;
        logic [6:0]  pixel_zoom;
        logic        mask_low_bit;
    } cfg_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } st_t;

    function automatic logic [2:0] element_size(input logic [3:0] mode);
        logic [2:0] n;
        case (mode)
            MODE_GRAY16_BIG, MODE_GRAY16_LITTLE, MODE_COLOR16: n = 3'd2;
            MODE_GRAY32_BIG, MODE_GRAY32_LITTLE, MODE_COLOR32: n = 3'd4;
            MODE_RGB: n = 3'd3;
            default: n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic rgb_t colorize(input logic [3:0] mode, input logic [31:0] w,
                                      input logic [7:0] prev);
        logic [7:0]  b0;
        logic [7:0]  v;
        logic [9:0]  p3;
        logic [10:0] p6;
        logic [2:0]  band;
        logic [8:0]  s;
        rgb_t        c;
        rgb_t        m;
        b0 = w[7:0];
        p3 = 10'(b0) * 10'd3;
        p6 = 11'(b0) * 11'd6;
        s = {1'b0, b0} + {1'b0, prev};
        c = '{b0, b0, b0};
        m = '{8'd0, 8'd0, 8'd0};
        v = 8'd0;
        band = 3'd0;
        case (mode)
            MODE_GRAY16_LITTLE: c = '{w[15:8], w[15:8], w[15:8]};
            MODE_GRAY32_LITTLE: c = '{w[31:24], w[31:24], w[31:24]};
            MODE_HUES:
            begin
                v = p3[7:0];
                case (p3[9:8])
                    2'd0: c = '{v, 8'd0, 8'd0};
                    2'd1: c = '{8'd0, v, 8'd0};
                    default: c = '{8'd0, 8'd0, v};
                endcase
            end
            MODE_HUES6:
            begin
                v = p6[7:0];
                band = p6[10:8];
                case (band)
                    3'd0: c = '{v, 8'd0, 8'd0};
                    3'd1: c = '{8'd0, v, 8'd0};
                    3'd2: c = '{8'd0, 8'd0, v};
                    3'd3: c = '{8'd0, v, v};
                    3'd4: c = '{v, 8'd0, v};
                    default: c = '{v, v, 8'd0};
                endcase
            end
            MODE_FHUES:
            begin
                v = p6[7:0];
                band = p6[10:8];
                case (band)
                    3'd0: c = '{v, 8'd0, 8'd0};
                    3'd1: c = '{8'hff, v, v};
                    3'd2: c = '{8'd0, v, 8'd0};
                    3'd3: c = '{v, 8'hff, v};
                    3'd4: c = '{8'd0, 8'd0, v};
                    default: c = '{v, v, 8'hff};
                endcase
            end
            MODE_COLOR: c = '{b0 & 8'he0, {b0[4:2], 5'd0}, {b0[1:0], 6'd0}};
            MODE_COLOR16: c = '{{w[15:10], 2'd0}, {w[9:6], 4'd0}, {w[4:0], 3'd0}};
            MODE_COLOR32: c = '{w[31:24], w[20:13], w[8:1]};
            MODE_RGB: c = '{w[7:0], w[15:8], w[23:16]};
            MODE_DVI: c = '{(b0 >= prev) ? b0 - prev : prev - b0, b0, s[8:1]};
            MODE_X86:
            begin
                m.r = (b0 == 8'h8b) ? MARK_HI : (b0 == 8'he8) ? MARK_MID :
                      (b0 == 8'h85) ? MARK_LO : 8'd0;
                m.g = (b0 == 8'h65) ? MARK_HI : (b0 == 8'h74) ? MARK_MID :
                      (b0 == 8'h61) ? MARK_LO : 8'd0;
                m.b = (b0 == 8'h01) ? MARK_HI : (b0 == 8'h02) ? MARK_MID :
                      (b0 == 8'h03) ? MARK_LO : 8'd0;
                if (m != '0)
                begin
                    c = m;
                end
            end
            default: c = '{b0, b0, b0};
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/byte_stream_pixel_colorizer_core.sv
// Top level of the byte stream pixel colorizer: configuration registers,
// input queue and pixel engine. Depends on bspc_pkg, bspc_queue, bspc_back.
//
//  channel   direction  handshake          payload
//  in        input      in_valid/in_stall  in_data (data_byte, end_of_data)
//  out       output     out_valid/out_stall out_data (red .. final_res)
//  cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A byte that ends no pixel is taken in the idle state; one that yields a filler
// item passes through the output state, which waits out output stall; a byte
// that completes a pixel first passes the 14-step serial divider that averages
// the zoom group, then the output state.
// A four-entry queue in front takes bytes while the engine is busy.
// Reset restores the register defaults and empties the stream state.
module byte_stream_pixel_colorizer_core import bspc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    cfg_t cfg_reg;
    logic q_valid;
    in_t  q_data;
    logic q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{MODE_X86, 13'd1024, 7'd1, 7'd1, 1'b1};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PALETTE_MODE: cfg_reg.palette_mode <= cfg_data[3:0];
                CFG_ROW_WIDTH: cfg_reg.row_width <= cfg_data;
                CFG_ROW_SKIP: cfg_reg.row_skip <= cfg_data[6:0];
                CFG_PIXEL_ZOOM: cfg_reg.pixel_zoom <= cfg_data[6:0];
                CFG_MASK_LOW_BIT: cfg_reg.mask_low_bit <= cfg_data[0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    bspc_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .q_valid(q_valid),
        .q_data(q_data),
        .q_pop(q_pop)
    );

    bspc_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .q_valid(q_valid),
        .q_data(q_data),
        .q_pop(q_pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

endmodule

### hw/rtl/bspc_queue.sv
// Front part: accepts input items and holds them in a short queue.
// Depends on bspc_pkg.
module bspc_queue import bspc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic q_valid,
    output in_t  q_data,
    input  logic q_pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    in_t           mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          push;
    logic          pop;

    assign in_stall = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign push = in_valid && !in_stall;
    assign q_valid = (count_reg != '0);
    assign pop = q_pop && q_valid;
    assign q_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

### hw/rtl/bspc_back.sv
// Back part: assembles elements, colors them, averages zoom groups with a
// bit-serial divider and tracks rows and dropped bytes. Depends on bspc_pkg.
`include "byte_stream_pixel_colorizer_core_macros.svh"
module bspc_back import bspc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic q_valid,
    input  in_t  q_data,
    output logic q_pop,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    localparam int SW = 14;
    localparam int PRW = 26;

    st_t            state_reg;
    st_t            state_next;
    logic [31:0]    elem_reg;
    logic [1:0]     phase_reg;
    logic [6:0]     zcnt_reg;
    logic [SW-1:0]  sum_reg [3];
    logic [11:0]    column_reg;
    logic [PRW-1:0] skip_reg;
    logic [7:0]     prev_reg;
    logic [SW-1:0]  num_reg [3];
    logic [5:0]     rem_reg [3];
    logic [3:0]     cnt_reg;
    logic [PRW-1:0] prod_reg;
    logic           pend_row_end_reg;
    logic           pend_eod_reg;
    logic           out_valid_reg;
    out_t           out_reg;

    logic [12:0]    width_c;
    logic [6:0]     zoom_c;
    logic [6:0]     skip_c;
    logic [2:0]     chrs;
    logic [31:0]    w_cur;
    rgb_t           c;
    logic [SW-1:0]  add [3];
    logic [6:0]     zcnt_inc;
    logic           elem_done;
    logic           pix_done;
    logic           row_end;
    logic           take;
    logic           eod;
    logic [6:0]     trial [3];
    logic           ge [3];
    logic [SW-1:0]  quo [3];
    logic [7:0]     chan [3];

    always_comb
    begin
        width_c = (cfg.row_width == '0) ? 13'd1 :
                  (cfg.row_width > 13'(MAX_ROW_WIDTH)) ? 13'(MAX_ROW_WIDTH) : cfg.row_width;
        zoom_c = (cfg.pixel_zoom == '0) ? 7'd1 :
                 (cfg.pixel_zoom > 7'(MAX_ZOOM)) ? 7'(MAX_ZOOM) : cfg.pixel_zoom;
        skip_c = (cfg.row_skip == '0) ? 7'd1 :
                 (cfg.row_skip > 7'(MAX_SKIP)) ? 7'(MAX_SKIP) : cfg.row_skip;
        chrs = element_size(cfg.palette_mode);
        eod = q_data.end_of_data;
        w_cur = elem_reg | (32'(q_data.data_byte) << {phase_reg, 3'b000});
        elem_done = (3'(phase_reg) + 3'd1) >= chrs;
        c = colorize(cfg.palette_mode, w_cur, prev_reg);
        add[0] = sum_reg[0] + SW'(c.r);
        add[1] = sum_reg[1] + SW'(c.g);
        add[2] = sum_reg[2] + SW'(c.b);
        zcnt_inc = zcnt_reg + 7'd1;
        pix_done = zcnt_inc >= zoom_c;
        row_end = (13'(column_reg) + 13'd1) >= width_c;
        for (int k = 0; k < 3; k++)
        begin
            trial[k] = {rem_reg[k], num_reg[k][SW-1]};
            ge[k] = trial[k] >= zoom_c;
            quo[k] = {num_reg[k][SW-2:0], ge[k]};
            chan[k] = quo[k][7:0] & {7'h7f, !cfg.mask_low_bit};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && skip_reg == '0)
                begin
                    if (elem_done && pix_done)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (eod)
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = 1'b0;
        case (state_reg)
            ST_IDLE: q_pop = q_valid;
            default: q_pop = 1'b0;
        endcase
    end

    assign take = q_pop;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            elem_reg <= '0;
            phase_reg <= '0;
            zcnt_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k] <= '0;
            end
            column_reg <= '0;
            skip_reg <= '0;
            prev_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                if (eod)
                begin
                    // End of data returns the stream to its reset state.
                    elem_reg <= '0;
                    phase_reg <= '0;
                    zcnt_reg <= '0;
                    for (int k = 0; k < 3; k++)
                    begin
                        sum_reg[k] <= '0;
                    end
                    column_reg <= '0;
                    skip_reg <= '0;
                    prev_reg <= '0;
                    if (skip_reg == '0)
                    begin
                        if (elem_done && pix_done)
                        begin
                            cnt_reg <= 4'(SW - 1);
                        end
                        else
                        begin
                            // A filler item is black padding in the current column.
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                else if (skip_reg != '0)
                begin
                    skip_reg <= skip_reg - PRW'(1);
                end
                else if (!elem_done)
                begin
                    elem_reg <= w_cur;
                    phase_reg <= phase_reg + 2'd1;
                    prev_reg <= q_data.data_byte;
                end
                else
                begin
                    prev_reg <= q_data.data_byte;
                    elem_reg <= '0;
                    phase_reg <= '0;
                    if (!pix_done)
                    begin
                        zcnt_reg <= zcnt_inc;
                        for (int k = 0; k < 3; k++)
                        begin
                            sum_reg[k] <= add[k];
                        end
                    end
                    else
                    begin
                        zcnt_reg <= '0;
                        for (int k = 0; k < 3; k++)
                        begin
                            sum_reg[k] <= '0;
                        end
                        cnt_reg <= 4'(SW - 1);
                        column_reg <= row_end ? 12'd0 : column_reg + 12'd1;
                    end
                end
            end
            if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == '0)
                begin
                    out_valid_reg <= 1'b1;
                    if (pend_row_end_reg && !pend_eod_reg)
                    begin
                        skip_reg <= prod_reg;
                    end
                end
            end
            if (state_reg == ST_OUT && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Divider, row-skip product and output register datapath, no reset needed.
    always_ff @(posedge clk)
    begin
        if (take && skip_reg == '0)
        begin
            if (elem_done && pix_done)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    num_reg[k] <= add[k];
                    rem_reg[k] <= '0;
                end
                pend_row_end_reg <= row_end;
                pend_eod_reg <= eod;
                prod_reg <= PRW'(6'(skip_c - 7'd1)) * PRW'(width_c);
            end
            else if (eod)
            begin
                out_reg <= '{8'd0, 8'd0, 8'd0, row_end, 1'b1, 1'b1};
            end
        end
        if (state_reg == ST_DIV)
        begin
            for (int k = 0; k < 3; k++)
            begin
                num_reg[k] <= quo[k];
                rem_reg[k] <= ge[k] ? 6'(trial[k] - zoom_c) : trial[k][5:0];
            end
            if (cnt_reg == 4'(SW - 1))
            begin
                prod_reg <= PRW'(prod_reg * PRW'(zoom_c));
            end
            else if (cnt_reg == 4'(SW - 2))
            begin
                prod_reg <= PRW'(prod_reg * PRW'(chrs));
            end
            if (cnt_reg == '0)
            begin
                out_reg <= '{chan[0], chan[1], chan[2], pend_row_end_reg, 1'b0,
                             pend_eod_reg};
            end
        end
    end

    `BSPC_ASSERT(a_valid_in_out, clk, rst_n, out_valid_reg |-> state_reg == ST_OUT, "result without output state")
    `BSPC_NEVER(a_pop_busy, clk, rst_n, q_pop && state_reg != ST_IDLE, "item taken while busy")
    `BSPC_ASSERT(a_div_end, clk, rst_n, (state_reg == ST_DIV && cnt_reg == '0) |=> out_valid_reg, "division ended without result")
    `BSPC_NEVER(a_skip_busy, clk, rst_n, state_reg == ST_DIV && skip_reg != '0, "dropping bytes during a pixel")

endmodule
